[design/ipsc_pkg.sv]
// ----------------------------------------------------------------------------
// ipsc_pkg
// Types and constants shared by the incremental PI speed controller.
// ----------------------------------------------------------------------------
package ipsc_pkg;

  localparam int NUM_CHANNELS    = 2;
  localparam int SPEED_FRAC_BITS = 12;
  localparam int GAIN_FRAC_BITS  = 8;
  localparam int ACC_FRAC_BITS   = SPEED_FRAC_BITS + GAIN_FRAC_BITS;

  localparam int SPEED_W  = 16;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int EDIFF_W  = ERR_W + 1;
  localparam int GAIN_W   = 24;
  localparam int DBAND_W  = 15;
  localparam int LIMIT_W  = 16;
  localparam int ACC_W    = 40;
  localparam int PPROP_W  = GAIN_W + 1 + EDIFF_W;
  localparam int PINT_W   = GAIN_W + 1 + ERR_W;
  localparam int PSUM_W   = PPROP_W + 1;
  localparam int SUM_W    = PSUM_W + 1;
  localparam int DRIVE_W  = 17;

  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int OFIFO_DEPTH = 8;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 24'd102400;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 24'd76800;
  localparam logic [DBAND_W-1:0] DEADBAND_RST    = 15'd41;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 16'd7200;

  typedef enum logic [1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_INTEG_GAIN  = 2'd1,
    REG_DEADBAND    = 2'd2,
    REG_DRIVE_LIMIT = 2'd3
  } ipsc_reg_t;

  typedef struct packed {
    logic                      channel;
    logic signed [SPEED_W-1:0] measured_speed;
    logic signed [SPEED_W-1:0] target_speed;
  } ipsc_in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      in_deadband;
    logic                      clamped;
  } ipsc_out_t;

endpackage

[design/incremental_pi_speed_controller_unit.sv]
// ----------------------------------------------------------------------------
// incremental_pi_speed_controller_unit
// Velocity form PI speed controller with deadband, one controller per channel.
// ----------------------------------------------------------------------------
// The block takes one measurement transfer per cycle while meas_stall is low
// and returns exactly one drive transfer for each, in order, after it has
// passed stages one, two and three. The per-channel previous error and
// accumulator live in two small memories with a registered read; the error
// update is written back one stage after its read and the accumulator is
// updated in the last stage, with forwarding between neighboring items of the
// same channel, so items of any channel can follow each other in every cycle.
// Results wait in an eight-entry queue; meas_stall rises only when that queue
// and the three pipeline stages together could hold no further item.
// Configuration registers sit at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module incremental_pi_speed_controller_unit import ipsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  meas_valid,
  output logic                  meas_stall,
  input  ipsc_in_t              meas,
  output logic                  drive_valid,
  input  logic                  drive_stall,
  output ipsc_out_t             drive,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PTR_W = $clog2(OFIFO_DEPTH);

  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [DBAND_W-1:0] deadband;
  logic [LIMIT_W-1:0] drive_limit;

  logic signed [ERR_W-1:0] prev_mem [NUM_CHANNELS];
  logic signed [ACC_W-1:0] acc_mem  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] prev_ok;
  logic [NUM_CHANNELS-1:0] acc_ok;

  logic                    s1_valid;
  logic                    s1_ch;
  logic                    s1_in_range;
  logic                    s1_dead;
  logic signed [ERR_W-1:0] s1_err;
  logic signed [ERR_W-1:0] s1_prev_rdata;
  logic                    s1_prev_rvalid;
  logic                    s1_pfwd;
  logic signed [ERR_W-1:0] s1_pfwd_val;

  logic                      s2_valid;
  logic                      s2_ch;
  logic                      s2_in_range;
  logic                      s2_dead;
  logic signed [PPROP_W-1:0] s2_pprop;
  logic signed [PINT_W-1:0]  s2_pint;

  logic                     s3_valid;
  logic                     s3_ch;
  logic                     s3_in_range;
  logic                     s3_dead;
  logic signed [PSUM_W-1:0] s3_psum;
  logic signed [ACC_W-1:0]  s3_acc_rdata;
  logic                     s3_acc_rvalid;
  logic                     s3_afwd;
  logic signed [ACC_W-1:0]  s3_afwd_val;

  ipsc_out_t        fifo_mem [OFIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;
  logic [PTR_W:0]   count_next;

  logic                     accept;
  logic                     cfg_write;
  logic                     in_range;
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         err_mag;
  logic signed [ERR_W-1:0]  s1_prev;
  logic signed [EDIFF_W-1:0] s1_ediff;
  logic signed [PSUM_W-1:0] s2_psum;
  logic signed [ACC_W-1:0]  s3_acc;
  logic signed [SUM_W-1:0]  s3_sum;
  logic signed [SUM_W-1:0]  s3_bound;
  logic signed [SUM_W-1:0]  s3_val;
  logic signed [ACC_W-1:0]  s3_acc_next;
  logic                     s3_clip;
  logic signed [DRIVE_W-1:0] s3_drive;
  ipsc_out_t                s3_result;
  logic [1:0]               inflight;
  logic                     pop;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (ipsc_reg_t'(paddr[3:2]))
      REG_PROP_GAIN:   prdata = CFG_DATA_W'(prop_gain);
      REG_INTEG_GAIN:  prdata = CFG_DATA_W'(integ_gain);
      REG_DEADBAND:    prdata = CFG_DATA_W'(deadband);
      REG_DRIVE_LIMIT: prdata = CFG_DATA_W'(drive_limit);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      deadband    <= DEADBAND_RST;
      drive_limit <= DRIVE_LIMIT_RST;
    end else if (cfg_write) begin
      case (ipsc_reg_t'(paddr[3:2]))
        REG_PROP_GAIN:   prop_gain   <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain  <= pwdata[GAIN_W-1:0];
        REG_DEADBAND:    deadband    <= pwdata[DBAND_W-1:0];
        REG_DRIVE_LIMIT: drive_limit <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input side and error computation.
  assign inflight   = 2'(s1_valid) + 2'(s2_valid) + 2'(s3_valid);
  assign meas_stall = ({1'b0, count} + (PTR_W + 2)'(inflight))
                      >= (PTR_W + 2)'(OFIFO_DEPTH);
  assign accept     = meas_valid && !meas_stall;
  assign in_range   = int'(meas.channel) < NUM_CHANNELS;

  assign err     = ERR_W'(meas.target_speed) - ERR_W'(meas.measured_speed);
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  // Previous error memory: read at acceptance, written back from stage one.
  always_ff @(posedge clk) begin
    s1_prev_rdata <= prev_mem[meas.channel];
    if (s1_valid && s1_in_range) begin
      prev_mem[s1_ch] <= s1_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      prev_ok  <= '0;
    end else begin
      s1_valid <= accept;
      if (s1_valid && s1_in_range) begin
        prev_ok[s1_ch] <= 1'b1;
      end
    end
    s1_ch          <= meas.channel;
    s1_in_range    <= in_range;
    s1_err         <= err;
    s1_dead        <= err_mag < ERR_W'(deadband);
    s1_prev_rvalid <= prev_ok[meas.channel];
    s1_pfwd        <= s1_valid && s1_in_range && (s1_ch == meas.channel);
    s1_pfwd_val    <= s1_err;
  end

  assign s1_prev  = s1_pfwd ? s1_pfwd_val : (s1_prev_rvalid ? s1_prev_rdata : '0);
  assign s1_ediff = EDIFF_W'(s1_err) - EDIFF_W'(s1_prev);

  // Stage two holds the two products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_ch       <= s1_ch;
    s2_in_range <= s1_in_range;
    s2_dead     <= s1_dead;
    s2_pprop    <= $signed({1'b0, prop_gain}) * s1_ediff;
    s2_pint     <= $signed({1'b0, integ_gain}) * s1_err;
  end

  assign s2_psum = PSUM_W'(s2_pprop) + PSUM_W'(s2_pint);

  // Accumulator memory: read from stage two, written back from stage three.
  always_ff @(posedge clk) begin
    s3_acc_rdata <= acc_mem[s2_ch];
    if (s3_valid && s3_in_range) begin
      acc_mem[s3_ch] <= s3_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      acc_ok   <= '0;
    end else begin
      s3_valid <= s2_valid;
      if (s3_valid && s3_in_range) begin
        acc_ok[s3_ch] <= 1'b1;
      end
    end
    s3_ch         <= s2_ch;
    s3_in_range   <= s2_in_range;
    s3_dead       <= s2_dead;
    s3_psum       <= s2_psum;
    s3_acc_rvalid <= acc_ok[s2_ch];
    s3_afwd       <= s3_valid && s3_in_range && (s3_ch == s2_ch);
    s3_afwd_val   <= s3_acc_next;
  end

  // Accumulate and clamp, or hold the accumulator in the deadband; truncate toward zero.
  assign s3_acc   = s3_afwd ? s3_afwd_val : (s3_acc_rvalid ? s3_acc_rdata : '0);
  assign s3_sum   = SUM_W'(s3_acc) + SUM_W'(s3_psum);
  assign s3_bound = $signed(SUM_W'({drive_limit, {ACC_FRAC_BITS{1'b0}}}));

  always_comb begin
    s3_clip = 1'b0;
    s3_val  = s3_sum;
    if (s3_dead) begin
      s3_val = SUM_W'(s3_acc);
    end else if (s3_sum > s3_bound) begin
      s3_val  = s3_bound;
      s3_clip = 1'b1;
    end else if (s3_sum < -s3_bound) begin
      s3_val  = -s3_bound;
      s3_clip = 1'b1;
    end
  end

  assign s3_acc_next = s3_val[ACC_W-1:0];
  assign s3_drive    = s3_val[ACC_FRAC_BITS+DRIVE_W-1:ACC_FRAC_BITS]
                       + DRIVE_W'(s3_val[SUM_W-1] && (|s3_val[ACC_FRAC_BITS-1:0]));

  always_comb begin
    s3_result = '0;
    if (s3_in_range) begin
      s3_result.drive_value = s3_drive;
      s3_result.in_deadband = s3_dead;
      s3_result.clamped     = s3_clip;
    end
  end

  // Result queue.
  assign pop         = drive_valid && !drive_stall;
  assign drive_valid = count != '0;
  assign drive       = fifo_mem[rptr];
  assign count_next  = count + (PTR_W + 1)'(s3_valid) - (PTR_W + 1)'(pop);

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      fifo_mem[wptr] <= s3_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (s3_valid) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W + 1)'(OFIFO_DEPTH))
    else $error("result queue holds more entries than its depth");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_in_range && !s3_dead) |->
      (SUM_W'(s3_acc_next) <= s3_bound && SUM_W'(s3_acc_next) >= -s3_bound))
    else $error("updated accumulator lies beyond the drive limit");

  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> !(drive.clamped && drive.in_deadband))
    else $error("a result is both clamped and in the deadband");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == '0 && !s1_valid && !s2_valid && !s3_valid))
    else $error("pipeline or queue not empty after reset");

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    s3_afwd |-> $past(s3_valid))
    else $error("accumulator forwarded from an empty stage");

endmodule
